// File: rtl/core/positional_list_store_assert.svh
// Assertion macros used by the top file of the list store.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define PLS_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define PLS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/pls_pkg.sv
package pls_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int WORD_W = 32;
  localparam int POS_W = 8;
  localparam int ACT_W = 3;
  localparam int CAP_W = 8;
  localparam int CFG_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 8'd5;
  localparam logic [CAP_W-1:0] CAP_MAX = 8'd255;
  localparam logic [CAP_W-1:0] CAP_MIN = 8'd1;

  typedef enum logic [ACT_W-1:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_READ   = 3'd2,
    OP_DELETE = 3'd3,
    OP_COUNT  = 3'd4,
    OP_CAP    = 3'd5,
    OP_LIST   = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    BK_RUN  = 1'b0,
    BK_LIST = 1'b1
  } back_state_t;

  typedef struct packed {
    op_t                     op;
    logic                    nonneg;
    logic [POS_W-2:0]        pos;
    logic signed [WORD_W-1:0] word;
  } cmd_t;

endpackage

// File: rtl/core/pls_if.sv
interface pls_in_if;
  logic                                valid;
  logic                                ready;
  logic [pls_pkg::ACT_W-1:0]           action;
  logic signed [pls_pkg::POS_W-1:0]    position;
  logic signed [pls_pkg::WORD_W-1:0]   word_in;

  modport source (output valid, action, position, word_in, input ready);
  modport sink (input valid, action, position, word_in, output ready);
endinterface

interface pls_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pls_pkg::WORD_W-1:0]   word_out;
  logic [1:0]                          status;
  logic                                last_of_run;

  modport source (output valid, word_out, status, last_of_run, input ready);
  modport sink (input valid, word_out, status, last_of_run, output ready);
endinterface

// File: rtl/core/pls_front.sv
module pls_front (
  pls_in_if.sink         cmd,
  input  logic           q_full,
  output logic           push,
  output pls_pkg::cmd_t  push_data
);

  assign cmd.ready = !q_full;
  assign push = cmd.valid && !q_full;

  assign push_data.op = pls_pkg::op_t'(cmd.action);
  assign push_data.nonneg = !cmd.position[pls_pkg::POS_W-1];
  assign push_data.pos = cmd.position[pls_pkg::POS_W-2:0];
  assign push_data.word = cmd.word_in;

endmodule

// File: rtl/core/pls_queue.sv
module pls_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pls_pkg::cmd_t  push_data,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output pls_pkg::cmd_t  pop_data
);

  localparam int QD = 2;
  localparam int QAW = $clog2(QD);

  pls_pkg::cmd_t slots [QD];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;

  assign full = (fill == (QAW+1)'(QD));
  assign valid = (fill != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QAW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/core/pls_back.sv
module pls_back #(
  parameter int DEPTH = pls_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  pls_pkg::cmd_t                     cmd,
  input  logic                              cfg_we,
  input  logic [pls_pkg::CFG_W-1:0]         cfg_data,
  pls_out_if.source                         res,
  output logic [$clog2(DEPTH+1)-1:0]        entry_count,
  output logic [pls_pkg::CAP_W-1:0]         logical_capacity
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = pls_pkg::POS_W - 1;
  localparam int WW = pls_pkg::WORD_W;
  localparam int KW = pls_pkg::CAP_W;

  logic [WW-1:0] entries [DEPTH];

  pls_pkg::back_state_t state, state_next;
  logic [IW-1:0] idx, idx_next;
  logic [CW-1:0] count_next;
  logic [KW-1:0] cap_next;

  logic              ov;
  logic [WW-1:0]     o_word;
  pls_pkg::status_t  o_status;
  logic              o_last;

  logic              load;
  logic [WW-1:0]     ld_word;
  pls_pkg::status_t  ld_status;
  logic              ld_last;

  logic do_ins, do_app, do_del;
  logic out_free;
  logic [IW-1:0] rd_addr;
  logic [WW-1:0] rd_word;
  logic [PW-1:0] count_p;
  logic [CW-1:0] count_dec;
  logic [KW-1:0] cap_half;
  logic [KW-1:0] cap_grown;
  logic          is_full;

  assign out_free = !ov || res.ready;
  assign rd_addr = (state == pls_pkg::BK_LIST) ? idx : cmd.pos[IW-1:0];
  assign rd_word = entries[rd_addr];
  assign count_p = PW'(entry_count);
  assign count_dec = entry_count - CW'(1);
  assign cap_half = logical_capacity >> 1;
  assign is_full = (entry_count == CW'(DEPTH));
  assign cap_grown = (KW'(entry_count) >= logical_capacity) ?
                     (logical_capacity[KW-1] ? pls_pkg::CAP_MAX :
                      {logical_capacity[KW-2:0], 1'b0}) : logical_capacity;

  always_comb begin
    state_next = state;
    idx_next = idx;
    count_next = entry_count;
    cap_next = logical_capacity;
    q_pop = 1'b0;
    load = 1'b0;
    ld_word = '0;
    ld_status = pls_pkg::ST_OK;
    ld_last = 1'b1;
    do_ins = 1'b0;
    do_app = 1'b0;
    do_del = 1'b0;
    case (state)
      pls_pkg::BK_RUN: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          load = 1'b1;
          case (cmd.op)
            pls_pkg::OP_INSERT: begin
              if (!cmd.nonneg || cmd.pos > count_p) begin
                ld_status = pls_pkg::ST_INVALID;
              end else if (is_full) begin
                ld_status = pls_pkg::ST_FULL;
              end else begin
                do_ins = 1'b1;
                cap_next = cap_grown;
                count_next = entry_count + CW'(1);
              end
            end
            pls_pkg::OP_APPEND: begin
              if (is_full) begin
                ld_status = pls_pkg::ST_FULL;
              end else begin
                do_app = 1'b1;
                cap_next = cap_grown;
                count_next = entry_count + CW'(1);
              end
            end
            pls_pkg::OP_READ: begin
              if (!cmd.nonneg || cmd.pos >= count_p) begin
                ld_status = pls_pkg::ST_INVALID;
              end else begin
                ld_word = rd_word;
              end
            end
            pls_pkg::OP_DELETE: begin
              if (!cmd.nonneg || cmd.pos >= count_p) begin
                ld_status = pls_pkg::ST_INVALID;
              end else begin
                do_del = 1'b1;
                count_next = count_dec;
                if (KW'(count_dec) == cap_half) begin
                  cap_next = (cap_half == '0) ? pls_pkg::CAP_MIN : cap_half;
                end
              end
            end
            pls_pkg::OP_COUNT: ld_word = WW'(entry_count);
            pls_pkg::OP_CAP: ld_word = WW'(logical_capacity);
            pls_pkg::OP_LIST: begin
              load = 1'b0;
              if (entry_count != '0) begin
                state_next = pls_pkg::BK_LIST;
                idx_next = '0;
              end
            end
            default: ld_word = '0;
          endcase
        end
      end
      pls_pkg::BK_LIST: begin
        if (out_free) begin
          load = 1'b1;
          ld_word = rd_word;
          ld_last = (CW'(idx) == count_dec);
          idx_next = idx + IW'(1);
          if (ld_last) begin
            state_next = pls_pkg::BK_RUN;
          end
        end
      end
      default: state_next = pls_pkg::BK_RUN;
    endcase
    if (cfg_we) begin
      cap_next = (cfg_data == '0) ? pls_pkg::CAP_MIN : KW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pls_pkg::BK_RUN;
      idx <= '0;
      entry_count <= '0;
      logical_capacity <= pls_pkg::CAP_RESET;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      entry_count <= count_next;
      logical_capacity <= cap_next;
      if (load) begin
        ov <= 1'b1;
      end else if (res.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_word <= ld_word;
      o_status <= ld_status;
      o_last <= ld_last;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic [WW-1:0] from_below;
    logic [WW-1:0] from_above;
    logic          shift_down;
    if (i == 0) begin : g_first
      assign from_below = cmd.word;
    end else begin : g_mid
      assign from_below = entries[i-1];
    end
    if (i == DEPTH-1) begin : g_last
      assign from_above = entries[i];
      assign shift_down = 1'b0;
    end else begin : g_inner
      assign from_above = entries[i+1];
      assign shift_down = (PW'(i) >= cmd.pos);
    end
    always_ff @(posedge clk) begin
      if (do_ins) begin
        if (PW'(i) == cmd.pos) begin
          entries[i] <= cmd.word;
        end else if (PW'(i) > cmd.pos) begin
          entries[i] <= from_below;
        end
      end else if (do_app) begin
        if (PW'(i) == count_p) begin
          entries[i] <= cmd.word;
        end
      end else if (do_del) begin
        if (shift_down) begin
          entries[i] <= from_above;
        end
      end
    end
  end

  assign res.valid = ov;
  assign res.word_out = o_word;
  assign res.status = o_status;
  assign res.last_of_run = o_last;

endmodule

// File: rtl/core/positional_list_store.sv
// Ordered list of signed 32-bit words held in DEPTH register slots.
// The cmd channel takes one transaction per action (insert, append, read,
// delete, count, capacity, list all); the res channel returns the results,
// each carrying word_out, status and last_of_run.
// A cmd transaction is decoded into a two-entry command queue; the execution
// stage pops it from the queue and fills the output register, which drives
// the res channel.
// Every action except list all gives one result without holding the execution
// stage, so such transactions flow at one per cycle while res does not stall.
// List all is decoded first and then gives count results, one per cycle while
// res does not stall, holding the execution stage meanwhile (none if empty).
// Insert and delete shift the slots at and above the given position together.
// When res stalls, the output register holds its result, the queue fills,
// and cmd.ready drops once both queue entries are taken.
// The initial_capacity write loads the logical capacity at once (0 loads as
// 1); write it only while no transaction is outstanding.
// Synchronous reset empties the list and the queue and sets the capacity to
// 5. The slots are not cleared; only written slots are ever read.
module positional_list_store #(
  parameter int DEPTH = pls_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  pls_in_if.sink                     cmd,
  pls_out_if.source                  res,
  input  logic                       initial_capacity_we,
  input  logic [pls_pkg::CFG_W-1:0]  initial_capacity_wdata
);

  `include "positional_list_store_assert.svh"

  localparam int CW = $clog2(DEPTH+1);

  logic                      q_full;
  logic                      q_push;
  logic                      q_valid;
  logic                      q_pop;
  pls_pkg::cmd_t             q_in;
  pls_pkg::cmd_t             q_out;
  logic [CW-1:0]             entry_count;
  logic [pls_pkg::CAP_W-1:0] logical_capacity;

  pls_front u_front (
    .cmd       (cmd),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  pls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  pls_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .cmd              (q_out),
    .cfg_we           (initial_capacity_we),
    .cfg_data         (initial_capacity_wdata),
    .res              (res),
    .entry_count      (entry_count),
    .logical_capacity (logical_capacity)
  );

  `PLS_ASSERT_ALWAYS(a_cap_nonzero, logical_capacity != '0, "logical capacity reached zero")
  `PLS_ASSERT_ALWAYS(a_count_bound, entry_count <= CW'(DEPTH), "entry count exceeds depth")
  `PLS_ASSERT_IMP(a_run_ok, res.valid && !res.last_of_run, res.status == pls_pkg::ST_OK, "listing result with error status")
  `PLS_ASSERT_NEXT(a_cfg_load, initial_capacity_we, logical_capacity == ((|$past(initial_capacity_wdata)) ? {1'b0, $past(initial_capacity_wdata)} : pls_pkg::CAP_MIN), "capacity not loaded from register write")

endmodule
